>>> src/assert_macros.svh
// assertion macros shared by the look-at view matrix rtl
// expects clk and arst_n in the scope of each use

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked at every rising clock edge outside reset
`define LVM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every rising clock edge, reset included
`define LVM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LVM_ASSERT(lbl, prop, msg)

`define LVM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> src/lvm_pkg.sv
// shared widths, types and latencies of the look-at view matrix block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lvm_pkg;

	// input point component, Q15.16
	localparam int EW = 32;
	// vector component before normalization
	localparam int CW = 50;
	// unit vector component, Q.16 with sign
	localparam int QW = 18;
	// magnitude after common scaling, below 2^30
	localparam int MW = 30;
	// sum of squares
	localparam int SW = 62;
	// square root working register
	localparam int RW = SW + 1;
	// norm, below 2^31
	localparam int NW = 31;
	// root iterations, one per stage
	localparam int SQ_STEPS = SW / 2;
	// quotient bits, one per stage
	localparam int DIV_STEPS = 17;
	// rounded dividend width
	localparam int NUMW = MW + 16 + 1;
	// output column width, Q31.16
	localparam int CLW = 48;
	// dot product sum width
	localparam int DW = 51;

	// latency of one normalize unit
	localparam int UNIT_LAT = 7 + SQ_STEPS + 1 + DIV_STEPS + 1;
	// cross product stages
	localparam int CROSS_LAT = 2;
	// dot product and translation stages
	localparam int DOT_LAT = 3;
	// whole pipeline: input stage, three normalizations, two crosses, dot
	localparam int TOT_LAT = 1 + UNIT_LAT + 2 * (CROSS_LAT + UNIT_LAT) + DOT_LAT;
	// sideband lines after the first and second normalizations
	localparam int LINE_LAT = CROSS_LAT + UNIT_LAT;

	// Q31.16 one
	localparam logic [CLW-1:0] ONE_Q16 = CLW'(65536);

	typedef logic [2:0][EW-1:0] pt_t;
	typedef logic [2:0][CW-1:0] wvec_t;
	typedef logic [2:0][QW-1:0] ax_t;

	typedef enum logic [1:0] {
		ROW_RIGHT,
		ROW_UP,
		ROW_BACK,
		ROW_CONST
	} row_t;

	typedef struct packed {
		pt_t eye;
		pt_t up;
	} seg_a_t;

	typedef struct packed {
		pt_t  eye;
		ax_t  n;
		logic ok;
	} seg_b_t;

	typedef struct packed {
		pt_t  eye;
		ax_t  n;
		ax_t  u;
		logic ok;
	} seg_c_t;

endpackage

`default_nettype wire

>>> src/lvm_unitize.sv
// pipelined normalization of a three component vector to a Q.16 unit vector
// depends on lvm_pkg; advances when en is high
`timescale 1ns / 1ps
`default_nettype none

module lvm_unitize
	import lvm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire wvec_t c,
	output ax_t        q,
	output logic       ok
);

	localparam int NG  = (CW + 7) / 8;
	localparam int MBW = $clog2(CW);
	localparam logic [MBW-1:0] TGT = MBW'(MW - 1);

	// stage 1: magnitudes and signs
	logic [CW-1:0] m_s1 [3];
	logic [2:0]    neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= c[i][CW-1];
				m_s1[i]   <= c[i][CW-1] ? (~c[i] + CW'(1)) : c[i];
			end
		end
	end

	// stage 2: largest magnitude
	logic [CW-1:0] mx_c, mx_s2;
	logic [CW-1:0] m_s2 [3];
	logic [2:0]    neg_s2;

	always_comb begin
		mx_c = m_s1[0];
		if (m_s1[1] > mx_c) mx_c = m_s1[1];
		if (m_s1[2] > mx_c) mx_c = m_s1[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2  <= mx_c;
			m_s2   <= m_s1;
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: leading one inside each byte group
	logic [NG*8-1:0] mxp;
	logic [NG-1:0]   any_c, any_s3;
	logic [2:0]      pos_c [NG];
	logic [2:0]      pos_s3 [NG];
	logic [CW-1:0]   m_s3 [3];
	logic [2:0]      neg_s3;
	logic            zero_s3;

	assign mxp = (NG*8)'(mx_s2);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			any_c[g] = 1'b0;
			pos_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (mxp[g*8+b]) begin
					any_c[g] = 1'b1;
					pos_c[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			any_s3  <= any_c;
			pos_s3  <= pos_c;
			m_s3    <= m_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= (mx_s2 == '0);
		end
	end

	// stage 4: leading one of the largest magnitude
	logic [MBW-1:0] msb_c, msb_s4;
	logic [CW-1:0]  m_s4 [3];
	logic [2:0]     neg_s4;
	logic           zero_s4;

	always_comb begin
		msb_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (any_s3[g]) msb_c = MBW'(g * 8) + MBW'(pos_s3[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			msb_s4  <= msb_c;
			m_s4    <= m_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: common power of two scaling, right shifts truncate
	logic [MW-1:0] m_c5 [3];
	logic [MW-1:0] m_s5 [3];
	logic [2:0]    neg_s5;
	logic          zero_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (msb_s4 > TGT) m_c5[i] = MW'(m_s4[i] >> (msb_s4 - TGT));
			else m_c5[i] = MW'(m_s4[i] << (TGT - msb_s4));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s5    <= m_c5;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	// stage 6: squares
	logic [2*MW-1:0] sq_s6 [3];
	logic [MW-1:0]   m_s6 [3];
	logic [2:0]      neg_s6;
	logic            zero_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s6[i] <= m_s5[i] * m_s5[i];
			m_s6    <= m_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	// stage 7: sum of squares
	logic [SW-1:0] sum_s7;
	logic [MW-1:0] m_s7 [3];
	logic [2:0]    neg_s7;
	logic          zero_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			m_s7    <= m_s6;
			neg_s7  <= neg_s6;
			zero_s7 <= zero_s6;
		end
	end

	// square root, one result bit per stage
	logic [SW-1:0] x_in [SQ_STEPS];
	logic [RW-1:0] r_in [SQ_STEPS];
	logic [SW-1:0] x_nx [SQ_STEPS];
	logic [RW-1:0] r_nx [SQ_STEPS];
	logic [SW-1:0] x_sq [SQ_STEPS];
	logic [RW-1:0] r_sq [SQ_STEPS];
	logic [MW-1:0] m_sq [SQ_STEPS][3];
	logic [2:0]    neg_sq [SQ_STEPS];
	logic          zero_sq [SQ_STEPS];

	always_comb begin
		x_in[0] = sum_s7;
		r_in[0] = '0;
		for (int k = 1; k < SQ_STEPS; k++) begin
			x_in[k] = x_sq[k-1];
			r_in[k] = r_sq[k-1];
		end
	end

	always_comb begin
		logic [RW-1:0] bk;
		logic [RW-1:0] tr;
		for (int k = 0; k < SQ_STEPS; k++) begin
			bk = RW'(1) << (SW - 2 - 2 * k);
			tr = r_in[k] + bk;
			if ({1'b0, x_in[k]} >= tr) begin
				x_nx[k] = x_in[k] - tr[SW-1:0];
				r_nx[k] = (r_in[k] >> 1) + bk;
			end else begin
				x_nx[k] = x_in[k];
				r_nx[k] = r_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_sq    <= x_nx;
			r_sq    <= r_nx;
			m_sq[0]    <= m_s7;
			neg_sq[0]  <= neg_s7;
			zero_sq[0] <= zero_s7;
			for (int k = 1; k < SQ_STEPS; k++) begin
				m_sq[k]    <= m_sq[k-1];
				neg_sq[k]  <= neg_sq[k-1];
				zero_sq[k] <= zero_sq[k-1];
			end
		end
	end

	// rounded dividend: magnitude in Q.16 plus half the norm
	logic [NW-1:0]   nrm_c;
	logic [NW-1:0]   nrm_dp;
	logic [NUMW-1:0] num_dp [3];
	logic [2:0]      neg_dp;
	logic            zero_dp;

	assign nrm_c = r_sq[SQ_STEPS-1][NW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_dp <= nrm_c;
			for (int i = 0; i < 3; i++) begin
				num_dp[i] <= {1'b0, m_sq[SQ_STEPS-1][i], 16'b0} + NUMW'(nrm_c >> 1);
			end
			neg_dp  <= neg_sq[SQ_STEPS-1];
			zero_dp <= zero_sq[SQ_STEPS-1];
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	logic [NW-1:0]        rem_in [DIV_STEPS][3];
	logic [DIV_STEPS-1:0] lo_in  [DIV_STEPS][3];
	logic [DIV_STEPS-1:0] quo_in [DIV_STEPS][3];
	logic [NW-1:0]        rem_nx [DIV_STEPS][3];
	logic [DIV_STEPS-1:0] quo_nx [DIV_STEPS][3];
	logic [NW-1:0]        rem_dv [DIV_STEPS][3];
	logic [DIV_STEPS-1:0] lo_dv  [DIV_STEPS][3];
	logic [DIV_STEPS-1:0] quo_dv [DIV_STEPS][3];
	logic [NW-1:0]        nrm_dv [DIV_STEPS];
	logic [2:0]           neg_dv [DIV_STEPS];
	logic                 zero_dv [DIV_STEPS];
	logic [NW-1:0]        nrm_in [DIV_STEPS];

	always_comb begin
		nrm_in[0] = nrm_dp;
		for (int i = 0; i < 3; i++) begin
			rem_in[0][i] = NW'(num_dp[i][NUMW-1:DIV_STEPS]);
			lo_in[0][i]  = num_dp[i][DIV_STEPS-1:0];
			quo_in[0][i] = '0;
		end
		for (int j = 1; j < DIV_STEPS; j++) begin
			nrm_in[j] = nrm_dv[j-1];
			rem_in[j] = rem_dv[j-1];
			lo_in[j]  = lo_dv[j-1];
			quo_in[j] = quo_dv[j-1];
		end
	end

	always_comb begin
		logic [NW:0] tr;
		for (int j = 0; j < DIV_STEPS; j++) begin
			for (int i = 0; i < 3; i++) begin
				tr = {rem_in[j][i], lo_in[j][i][DIV_STEPS-1-j]};
				if (tr >= {1'b0, nrm_in[j]}) begin
					rem_nx[j][i] = NW'(tr - {1'b0, nrm_in[j]});
					quo_nx[j][i] = {quo_in[j][i][DIV_STEPS-2:0], 1'b1};
				end else begin
					rem_nx[j][i] = NW'(tr);
					quo_nx[j][i] = {quo_in[j][i][DIV_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_dv <= rem_nx;
			quo_dv <= quo_nx;
			lo_dv  <= lo_in;
			nrm_dv <= nrm_in;
			neg_dv[0]  <= neg_dp;
			zero_dv[0] <= zero_dp;
			for (int j = 1; j < DIV_STEPS; j++) begin
				neg_dv[j]  <= neg_dv[j-1];
				zero_dv[j] <= zero_dv[j-1];
			end
		end
	end

	// final stage: sign back on, zero vector gives zeros
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_dv[DIV_STEPS-1]) q[i] <= '0;
				else if (neg_dv[DIV_STEPS-1][i])
					q[i] <= QW'(~{1'b0, quo_dv[DIV_STEPS-1][i]} + 1'b1);
				else q[i] <= QW'({1'b0, quo_dv[DIV_STEPS-1][i]});
			end
			ok <= ~zero_dv[DIV_STEPS-1];
		end
	end

endmodule

`default_nettype wire

>>> src/lookat_view_matrix.sv
// Look-at view matrix: one item of eye, center and up points (Q15.16) in, four
// matrix row items out (right, up, back, constant row) in Q31.16. The datapath
// is one stalling pipeline of 179 register stages: three normalize units of 57
// stages each (31 square root stages and 17 division stages), two cross
// product stages after the first and second, and three dot product stages for
// the translation column. An item enters in every cycle while the pipeline
// moves; the row serializer at the end sends four rows per item and takes the
// next finished item when idle or as the constant row is accepted; a finished
// item left waiting stalls the pipeline. A zero-length vector sets degenerate
// and zeros rows 0 to 2; row 3 is always 0,0,0,1. No state survives an item
// and there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lookat_view_matrix
	import lvm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z
	input  wire logic [287:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// col_0, col_1, col_2, col_3
	output logic [191:0]      m_tdata,
	// row_index, degenerate
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);

	logic en;
	logic load;
	logic vld_last;
	logic [TOT_LAT-1:0] vld_q;

	// valid bits travel with the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT_LAT-2:0], s_tvalid};
		end
	end

	assign vld_last = vld_q[TOT_LAT-1];
	assign s_tready = en;

	// input stage: split fields and form eye minus center
	pt_t   eye_p1, up_p1;
	wvec_t dv_p1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				eye_p1[i] <= s_tdata[EW*i +: EW];
				up_p1[i]  <= s_tdata[EW*(6+i) +: EW];
				dv_p1[i]  <= CW'($signed(s_tdata[EW*i +: EW]))
					- CW'($signed(s_tdata[EW*(3+i) +: EW]));
			end
		end
	end

	// back axis n
	ax_t  n_a;
	logic ok_a;

	lvm_unitize u_unit_n (
		.clk (clk),
		.en  (en),
		.c   (dv_p1),
		.q   (n_a),
		.ok  (ok_a)
	);

	seg_a_t ln_a_q [UNIT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			ln_a_q[0] <= '{eye: eye_p1, up: up_p1};
			for (int k = 1; k < UNIT_LAT; k++) ln_a_q[k] <= ln_a_q[k-1];
		end
	end

	// cross product up x n
	logic signed [EW-1:0] up_v [3];
	logic signed [QW-1:0] n_v [3];
	logic signed [CW-1:0] pr1_c [6];
	logic signed [CW-1:0] pr1_c1 [6];
	wvec_t                cu_c2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			up_v[i] = $signed(ln_a_q[UNIT_LAT-1].up[i]);
			n_v[i]  = $signed(n_a[i]);
		end
		pr1_c[0] = up_v[1] * n_v[2];
		pr1_c[1] = n_v[1] * up_v[2];
		pr1_c[2] = up_v[2] * n_v[0];
		pr1_c[3] = n_v[2] * up_v[0];
		pr1_c[4] = up_v[0] * n_v[1];
		pr1_c[5] = n_v[0] * up_v[1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr1_c1   <= pr1_c;
			cu_c2[0] <= pr1_c1[0] - pr1_c1[1];
			cu_c2[1] <= pr1_c1[2] - pr1_c1[3];
			cu_c2[2] <= pr1_c1[4] - pr1_c1[5];
		end
	end

	seg_b_t ln_b_q [LINE_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			ln_b_q[0] <= '{eye: ln_a_q[UNIT_LAT-1].eye, n: n_a, ok: ok_a};
			for (int k = 1; k < LINE_LAT; k++) ln_b_q[k] <= ln_b_q[k-1];
		end
	end

	// right axis u
	ax_t  u_b;
	logic ok_b;

	lvm_unitize u_unit_u (
		.clk (clk),
		.en  (en),
		.c   (cu_c2),
		.q   (u_b),
		.ok  (ok_b)
	);

	// cross product n x u
	logic signed [QW-1:0] nb_v [3];
	logic signed [QW-1:0] u_v [3];
	logic signed [CW-1:0] pr2_c [6];
	logic signed [CW-1:0] pr2_c1 [6];
	wvec_t                cv_c2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nb_v[i] = $signed(ln_b_q[LINE_LAT-1].n[i]);
			u_v[i]  = $signed(u_b[i]);
		end
		pr2_c[0] = nb_v[1] * u_v[2];
		pr2_c[1] = u_v[1] * nb_v[2];
		pr2_c[2] = nb_v[2] * u_v[0];
		pr2_c[3] = u_v[2] * nb_v[0];
		pr2_c[4] = nb_v[0] * u_v[1];
		pr2_c[5] = u_v[0] * nb_v[1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr2_c1   <= pr2_c;
			cv_c2[0] <= pr2_c1[0] - pr2_c1[1];
			cv_c2[1] <= pr2_c1[2] - pr2_c1[3];
			cv_c2[2] <= pr2_c1[4] - pr2_c1[5];
		end
	end

	seg_c_t ln_c_q [LINE_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			ln_c_q[0] <= '{
				eye: ln_b_q[LINE_LAT-1].eye,
				n:   ln_b_q[LINE_LAT-1].n,
				u:   u_b,
				ok:  ln_b_q[LINE_LAT-1].ok & ok_b
			};
			for (int k = 1; k < LINE_LAT; k++) ln_c_q[k] <= ln_c_q[k-1];
		end
	end

	// true up axis v
	ax_t  v_c;
	logic ok_c;

	lvm_unitize u_unit_v (
		.clk (clk),
		.en  (en),
		.c   (cv_c2),
		.q   (v_c),
		.ok  (ok_c)
	);

	// dot stage 1: axis times eye products, rows in order u, v, n
	ax_t                  ax_c [3];
	logic signed [DW-1:0] pd_c [3][3];
	logic signed [DW-1:0] pd_d1 [3][3];
	ax_t                  ax_d1 [3];
	logic                 ok_d1;

	always_comb begin
		ax_c[0] = ln_c_q[LINE_LAT-1].u;
		ax_c[1] = v_c;
		ax_c[2] = ln_c_q[LINE_LAT-1].n;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				pd_c[k][i] = $signed(ax_c[k][i]) * $signed(ln_c_q[LINE_LAT-1].eye[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_d1 <= pd_c;
			ax_d1 <= ax_c;
			ok_d1 <= ln_c_q[LINE_LAT-1].ok & ok_c;
		end
	end

	// dot stage 2: sum plus half an lsb
	logic signed [DW-1:0] sum_d2 [3];
	ax_t                  ax_d2 [3];
	logic                 ok_d2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sum_d2[k] <= pd_d1[k][0] + pd_d1[k][1] + pd_d1[k][2] + DW'(32768);
			end
			ax_d2 <= ax_d1;
			ok_d2 <= ok_d1;
		end
	end

	// dot stage 3: drop the fraction and negate
	logic [CLW-1:0] col3_d3 [3];
	ax_t            ax_d3 [3];
	logic           ok_d3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				col3_d3[k] <= CLW'(-(CLW'($signed(sum_d2[k][DW-1:16]))));
			end
			ax_d3 <= ax_d2;
			ok_d3 <= ok_d2;
		end
	end

	// row serializer control
	logic busy_q;
	row_t row_q;

	assign load = vld_last && (!busy_q || (m_tready && row_q == ROW_CONST));
	assign en   = !vld_last || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= ROW_RIGHT;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= ROW_RIGHT;
		end else if (busy_q && m_tready) begin
			if (row_q == ROW_CONST) busy_q <= 1'b0;
			else row_q <= row_t'(row_q + 2'd1);
		end
	end

	// row payload, zeroed for a degenerate item
	logic [4*CLW-1:0] rows_q [3];
	logic             deg_q;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < 3; k++) begin
				if (ok_d3) begin
					rows_q[k] <= {col3_d3[k],
						CLW'($signed(ax_d3[k][2])),
						CLW'($signed(ax_d3[k][1])),
						CLW'($signed(ax_d3[k][0]))};
				end else begin
					rows_q[k] <= '0;
				end
			end
			deg_q <= ~ok_d3;
		end
	end

	// output mux
	always_comb begin
		unique case (row_q)
			ROW_RIGHT: m_tdata = rows_q[0];
			ROW_UP:    m_tdata = rows_q[1];
			ROW_BACK:  m_tdata = rows_q[2];
			ROW_CONST: m_tdata = {ONE_Q16, {(3*CLW){1'b0}}};
			default:   m_tdata = '0;
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tuser  = {deg_q, row_q};
	assign m_tlast  = (row_q == ROW_CONST);

	// checks
	`LVM_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !m_tvalid, "output valid during reset")
	`LVM_ASSERT(a_held_when_blocked, (vld_last && !en) |=> (vld_last && m_tvalid),
		"finished item lost while output blocked")
	`LVM_ASSERT(a_row_advance, (m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && (row_q == $past(row_q) + 2'd1)), "row sequence broken")
	`LVM_ASSERT(a_degenerate_zero, (m_tvalid && m_tuser[2] && !m_tlast) |-> (m_tdata == '0),
		"degenerate row carries data")

endmodule

`default_nettype wire
